// File: sv/pfrrq_pkg.sv
// Package with constants, status codes and widths for the per-flow round-robin queue unit.
`default_nettype none
package pfrrq_pkg;

	localparam int NUM_FLOWS   = 16;
	localparam int QUEUE_DEPTH = 64;

	localparam int FLOW_W    = $clog2(NUM_FLOWS);
	localparam int OPEN_W    = $clog2(NUM_FLOWS + 1);
	localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
	localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W    = FLOW_W + SLOT_W;
	localparam int STORE_LEN = NUM_FLOWS * QUEUE_DEPTH;

	localparam int FLOW_ID_W = 8;
	localparam int HANDLE_W  = 32;
	localparam int LIMIT_W   = 7;
	localparam int OUT_FLOW_W = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_DEQUEUE = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		ST_ENQ       = 3'd0,
		ST_DROP_UNCL = 3'd1,
		ST_DROP_FULL = 3'd2,
		ST_DEQ       = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

endpackage
`default_nettype wire

// File: sv/pfrrq_if.sv
// Handshake interfaces for the request, response and configuration channels.
`default_nettype none
interface pfrrq_req_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic                                unclassified;
	logic [pfrrq_pkg::FLOW_ID_W-1:0]     flow_id;
	logic [pfrrq_pkg::HANDLE_W-1:0]      packet_handle;

	modport source (output valid, command, unclassified, flow_id, packet_handle, input ready);
	modport sink (input valid, command, unclassified, flow_id, packet_handle, output ready);
endinterface

interface pfrrq_rsp_if;
	logic                                valid;
	logic                                ready;
	pfrrq_pkg::status_t                  status;
	logic [pfrrq_pkg::OUT_FLOW_W-1:0]    out_flow;
	logic [pfrrq_pkg::HANDLE_W-1:0]      out_handle;

	modport source (output valid, status, out_flow, out_handle, input ready);
	modport sink (input valid, status, out_flow, out_handle, output ready);
endinterface

interface pfrrq_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pfrrq_pkg::LIMIT_W-1:0]       data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: sv/per_flow_round_robin_queue_unit.sv
// Per-flow packet queues with a round-robin dequeue scheduler.
//
// The req channel carries one word per command: an enqueue of a packet handle
// to a classified flow, or a dequeue of the next waiting packet. Every request
// word yields exactly one response word on the rsp channel with a status, the
// flow concerned and, for a dequeue, the packet handle. The cfg channel sets
// the per-flow queue limit and is always ready.
// In the accept cycle a request updates the flow state and issues the packet
// store access, and the next cycle captures the store's read data into the
// response register. No new request is taken while busy_s1 marks one still
// in flight, since the packet store read is registered.
// The scheduler finds the next non-empty flow combinationally with a rotating
// priority encoder over the per-flow non-empty bits.
// Reset clears the open flow count, the round-robin pointer and all fill
// and head counters, and sets the limit to 64; the packet store keeps its
// contents. While a response waits on a stalled receiver no new request is
// accepted.
`default_nettype none
module per_flow_round_robin_queue_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pfrrq_cfg_if.sink        cfg,
	pfrrq_req_if.sink        req,
	pfrrq_rsp_if.source      rsp
);

	localparam int NF = pfrrq_pkg::NUM_FLOWS;

	logic [pfrrq_pkg::LIMIT_W-1:0]  queue_limit_q;
	logic [pfrrq_pkg::OPEN_W-1:0]   flows_open_q;
	logic [pfrrq_pkg::FLOW_W-1:0]   rr_pointer_q;
	logic [pfrrq_pkg::FILL_W-1:0]   queue_fill_q [NF];
	logic [pfrrq_pkg::SLOT_W-1:0]   queue_head_q [NF];
	logic [pfrrq_pkg::HANDLE_W-1:0] packet_store [pfrrq_pkg::STORE_LEN];

	logic                           busy_s1;
	pfrrq_pkg::status_t             status_s1;
	logic [pfrrq_pkg::FLOW_W-1:0]   flow_s1;
	logic [pfrrq_pkg::HANDLE_W-1:0] rd_data_s1;

	logic                           out_valid_q;
	pfrrq_pkg::status_t             status_q;
	logic [pfrrq_pkg::FLOW_W-1:0]   out_flow_q;
	logic [pfrrq_pkg::HANDLE_W-1:0] out_handle_q;

	logic                           accept;
	logic                           is_deq;
	logic [pfrrq_pkg::FILL_W-1:0]   eff_limit;
	logic [pfrrq_pkg::FLOW_W-1:0]   enq_flow;
	logic                           enq_drop;
	logic                           enq_opens;
	logic                           enq_full;
	logic [pfrrq_pkg::SLOT_W-1:0]   enq_slot;
	logic [NF-1:0]                  non_empty;
	logic [2*NF-1:0]                ne_twice;
	logic [NF-1:0]                  ne_rot;
	logic                           deq_found;
	logic [pfrrq_pkg::FLOW_W-1:0]   deq_offset;
	logic [pfrrq_pkg::FLOW_W-1:0]   deq_flow;
	logic [pfrrq_pkg::OPEN_W-1:0]   deq_next;
	logic                           mem_we;
	logic                           mem_re;
	logic [pfrrq_pkg::ADDR_W-1:0]   mem_addr;
	pfrrq_pkg::status_t             status_d;
	logic [pfrrq_pkg::FLOW_W-1:0]   flow_d;

	assign cfg.ready = 1'b1;
	assign req.ready = !busy_s1 && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_deq    = (req.command == pfrrq_pkg::CMD_DEQUEUE);

	always_comb begin
		for (int i = 0; i < NF; i++) begin
			non_empty[i] = (queue_fill_q[i] != '0);
		end
	end

	always_comb begin
		if (queue_limit_q > pfrrq_pkg::LIMIT_W'(pfrrq_pkg::QUEUE_DEPTH)) begin
			eff_limit = pfrrq_pkg::FILL_W'(pfrrq_pkg::QUEUE_DEPTH);
		end else begin
			eff_limit = pfrrq_pkg::FILL_W'(queue_limit_q);
		end
		enq_flow  = req.flow_id[pfrrq_pkg::FLOW_W-1:0];
		enq_drop  = req.unclassified
			|| (req.flow_id > pfrrq_pkg::FLOW_ID_W'(flows_open_q))
			|| (req.flow_id >= pfrrq_pkg::FLOW_ID_W'(NF));
		enq_opens = (req.flow_id == pfrrq_pkg::FLOW_ID_W'(flows_open_q));
		enq_full  = (queue_fill_q[enq_flow] >= eff_limit);
		enq_slot  = queue_head_q[enq_flow]
			+ queue_fill_q[enq_flow][pfrrq_pkg::SLOT_W-1:0];
	end

	always_comb begin
		ne_twice   = {non_empty, non_empty};
		ne_rot     = NF'(ne_twice >> rr_pointer_q);
		deq_found  = |ne_rot;
		deq_offset = '0;
		for (int i = NF - 1; i >= 0; i--) begin
			if (ne_rot[i]) begin
				deq_offset = pfrrq_pkg::FLOW_W'(i);
			end
		end
		deq_flow = rr_pointer_q + deq_offset;
		deq_next = pfrrq_pkg::OPEN_W'(deq_flow) + pfrrq_pkg::OPEN_W'(1);
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = {enq_flow, enq_slot};
		status_d = pfrrq_pkg::ST_ENQ;
		flow_d   = '0;
		if (is_deq) begin
			mem_addr = {deq_flow, queue_head_q[deq_flow]};
			if (deq_found) begin
				mem_re   = accept;
				status_d = pfrrq_pkg::ST_DEQ;
				flow_d   = deq_flow;
			end else begin
				status_d = pfrrq_pkg::ST_EMPTY;
			end
		end else if (enq_drop) begin
			status_d = pfrrq_pkg::ST_DROP_UNCL;
		end else if (enq_full) begin
			status_d = pfrrq_pkg::ST_DROP_FULL;
			flow_d   = enq_flow;
		end else begin
			mem_we   = accept;
			flow_d   = enq_flow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= pfrrq_pkg::LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			queue_limit_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flows_open_q <= '0;
			rr_pointer_q <= '0;
			for (int i = 0; i < NF; i++) begin
				queue_fill_q[i] <= '0;
				queue_head_q[i] <= '0;
			end
		end else if (accept) begin
			if (is_deq) begin
				if (deq_found) begin
					queue_fill_q[deq_flow] <= queue_fill_q[deq_flow] - pfrrq_pkg::FILL_W'(1);
					queue_head_q[deq_flow] <= queue_head_q[deq_flow] + pfrrq_pkg::SLOT_W'(1);
					if (deq_next >= flows_open_q) begin
						rr_pointer_q <= '0;
					end else begin
						rr_pointer_q <= deq_next[pfrrq_pkg::FLOW_W-1:0];
					end
				end
			end else if (!enq_drop) begin
				if (enq_opens) begin
					flows_open_q <= flows_open_q + pfrrq_pkg::OPEN_W'(1);
				end
				if (!enq_full) begin
					queue_fill_q[enq_flow] <= queue_fill_q[enq_flow] + pfrrq_pkg::FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			packet_store[mem_addr] <= req.packet_handle;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_s1 <= packet_store[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			flow_s1   <= flow_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			status_q   <= status_s1;
			out_flow_q <= flow_s1;
			if (status_s1 == pfrrq_pkg::ST_DEQ) begin
				out_handle_q <= rd_data_s1;
			end else begin
				out_handle_q <= '0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.out_flow   = pfrrq_pkg::OUT_FLOW_W'(out_flow_q);
	assign rsp.out_handle = out_handle_q;

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the per-flow round-robin queue unit.
`timescale 1ns / 100ps
module tb;

	typedef struct packed {
		pfrrq_pkg::command_t                   cmd;
		logic                                  uncl;
		logic [pfrrq_pkg::FLOW_ID_W-1:0]       flow;
		logic [pfrrq_pkg::HANDLE_W-1:0]        handle;
		logic                                  fixed;
		pfrrq_pkg::status_t                    st;
		logic [pfrrq_pkg::OUT_FLOW_W-1:0]      oflow;
		logic [pfrrq_pkg::HANDLE_W-1:0]        ohandle;
	} req_word_t;

	typedef struct packed {
		pfrrq_pkg::status_t                    st;
		logic [pfrrq_pkg::OUT_FLOW_W-1:0]      flow;
		logic [pfrrq_pkg::HANDLE_W-1:0]        handle;
	} rsp_word_t;

	localparam int DIR_ROWS = 17;

	logic clk;
	logic arst_n;

	pfrrq_cfg_if cfg();
	pfrrq_req_if req();
	pfrrq_rsp_if rsp();

	per_flow_round_robin_queue_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

	logic [pfrrq_pkg::LIMIT_W-1:0]  limit_q;
	int unsigned                    open_cnt;
	int unsigned                    rr_ptr;
	int unsigned                    fill_q [pfrrq_pkg::NUM_FLOWS];
	int unsigned                    head_q [pfrrq_pkg::NUM_FLOWS];
	logic [pfrrq_pkg::HANDLE_W-1:0] store_q [pfrrq_pkg::STORE_LEN];

	req_word_t dir_table [DIR_ROWS];
	req_word_t req_backlog [$];
	rsp_word_t rsp_expected [$];
	req_word_t cur_word;

	int unsigned gen_open;
	int          send_idle;
	int          recv_idle;
	logic        hold_armed;
	logic        rsp_hold;
	int          err_cnt;
	int          words_taken;
	int          rsp_checked;
	int          status_seen [5];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic rsp_word_t schedule_word(req_word_t w);
		rsp_word_t   r;
		int unsigned lim;
		int unsigned f;
		int unsigned slot;
		int unsigned i;
		r.st = pfrrq_pkg::ST_DROP_UNCL;
		r.flow = '0;
		r.handle = '0;
		if (w.cmd == pfrrq_pkg::CMD_ENQUEUE) begin
			lim = (limit_q > pfrrq_pkg::QUEUE_DEPTH) ? pfrrq_pkg::QUEUE_DEPTH : limit_q;
			if (w.uncl || w.flow > open_cnt || w.flow >= pfrrq_pkg::NUM_FLOWS)
				return r;
			f = w.flow;
			if (f == open_cnt)
				open_cnt++;
			r.flow = f[pfrrq_pkg::OUT_FLOW_W-1:0];
			if (fill_q[f] >= lim) begin
				r.st = pfrrq_pkg::ST_DROP_FULL;
				return r;
			end
			slot = (head_q[f] + fill_q[f]) % pfrrq_pkg::QUEUE_DEPTH;
			store_q[f * pfrrq_pkg::QUEUE_DEPTH + slot] = w.handle;
			fill_q[f]++;
			r.st = pfrrq_pkg::ST_ENQ;
			return r;
		end
		for (i = 0; i < open_cnt; i++) begin
			f = rr_ptr;
			rr_ptr++;
			if (rr_ptr >= open_cnt)
				rr_ptr = 0;
			if (fill_q[f] > 0) begin
				r.st = pfrrq_pkg::ST_DEQ;
				r.flow = f[pfrrq_pkg::OUT_FLOW_W-1:0];
				r.handle = store_q[f * pfrrq_pkg::QUEUE_DEPTH + head_q[f]];
				head_q[f] = (head_q[f] + 1) % pfrrq_pkg::QUEUE_DEPTH;
				fill_q[f]--;
				return r;
			end
		end
		r.st = pfrrq_pkg::ST_EMPTY;
		return r;
	endfunction

	function automatic void report_fault(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic void track_open(req_word_t w);
		if (w.cmd == pfrrq_pkg::CMD_ENQUEUE && !w.uncl && w.flow == gen_open
			&& gen_open < pfrrq_pkg::NUM_FLOWS)
			gen_open++;
	endfunction

	function automatic void push_word(req_word_t w);
		req_backlog.insert(req_backlog.size(), w);
		track_open(w);
	endfunction

	// Mix of classified enqueues to open flows or the next new one, dequeues and noise enqueues.
	task automatic push_random(input int n, input int unsigned cap);
		req_word_t   w;
		int unsigned hi;
		int unsigned pick;
		for (int k = 0; k < n; k++) begin
			w = '0;
			w.handle = $urandom;
			pick = $urandom_range(99);
			if (pick < 10) begin
				w.cmd = pfrrq_pkg::CMD_ENQUEUE;
				w.uncl = 1'($urandom_range(1));
				w.flow = pfrrq_pkg::FLOW_ID_W'($urandom_range(255));
			end else if (pick < 55) begin
				w.cmd = pfrrq_pkg::CMD_ENQUEUE;
				hi = (gen_open < cap || cap >= pfrrq_pkg::NUM_FLOWS) ? gen_open : gen_open - 1;
				if ($urandom_range(3) == 0)
					w.flow = pfrrq_pkg::FLOW_ID_W'(hi);
				else
					w.flow = pfrrq_pkg::FLOW_ID_W'($urandom_range(hi, 0));
			end else begin
				w.cmd = pfrrq_pkg::CMD_DEQUEUE;
				w.uncl = 1'($urandom_range(1));
				w.flow = pfrrq_pkg::FLOW_ID_W'($urandom_range(255));
			end
			push_word(w);
		end
	endtask

	task automatic push_burst();
		req_word_t w;
		for (int k = 0; k < 140; k++) begin
			w = '0;
			w.cmd = (k < 70) ? pfrrq_pkg::CMD_ENQUEUE : pfrrq_pkg::CMD_DEQUEUE;
			w.handle = $urandom;
			push_word(w);
		end
	endtask

	task automatic set_idling(input int s, input int r);
		send_idle <= s;
		recv_idle <= r;
	endtask

	task automatic set_queue_limit(input logic [pfrrq_pkg::LIMIT_W-1:0] v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do
			@(posedge clk);
		while (!(cfg.valid && cfg.ready));
		cfg.valid <= 1'b0;
		limit_q = v;
	endtask

	task automatic drain();
		while (req_backlog.size() != 0 || rsp_expected.size() != 0 || req.valid)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	always @(posedge clk) begin : req_drv
		rsp_word_t e;
		req_word_t w;
		if (req.valid && req.ready) begin
			words_taken++;
			e = schedule_word(cur_word);
			if (cur_word.fixed) begin
				e.st = cur_word.st;
				e.flow = cur_word.oflow;
				e.handle = cur_word.ohandle;
			end
			rsp_expected.insert(rsp_expected.size(), e);
		end
		if (!req.valid || req.ready) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
				w = req_backlog.pop_front();
				cur_word = w;
				req.valid <= 1'b1;
				req.command <= w.cmd;
				req.unclassified <= w.uncl;
				req.flow_id <= w.flow;
				req.packet_handle <= w.handle;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : rsp_chk
		rsp_word_t e;
		if (rsp.valid && rsp.ready) begin
			if (rsp_expected.size() == 0) begin
				report_fault($sformatf("unexpected word status %0d flow %0d handle %h",
					rsp.status, rsp.out_flow, rsp.out_handle));
			end else begin
				e = rsp_expected.pop_front();
				rsp_checked++;
				if (e.st <= pfrrq_pkg::ST_EMPTY)
					status_seen[e.st]++;
				if (rsp.status !== e.st || rsp.out_flow !== e.flow || rsp.out_handle !== e.handle)
					report_fault($sformatf(
						"mismatch: expected status %0d flow %0d handle %h, got %0d %0d %h",
						e.st, e.flow, e.handle, rsp.status, rsp.out_flow, rsp.out_handle));
			end
		end
		rsp.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle);
	end

	initial begin : rsp_hold_off
		rsp_hold = 1'b0;
		wait (hold_armed);
		repeat (40) @(posedge clk);
		rsp_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	initial begin : main_seq
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = pfrrq_pkg::CMD_ENQUEUE;
		req.unclassified = 1'b0;
		req.flow_id = '0;
		req.packet_handle = '0;
		cfg.valid = 1'b0;
		cfg.data = pfrrq_pkg::LIMIT_RESET;
		rsp.ready = 1'b0;
		hold_armed = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		err_cnt = 0;
		words_taken = 0;
		rsp_checked = 0;
		status_seen = '{default: 0};
		gen_open = 0;
		limit_q = pfrrq_pkg::LIMIT_RESET;
		open_cnt = 0;
		rr_ptr = 0;
		fill_q = '{default: 0};
		head_q = '{default: 0};

		dir_table[0]  = '{pfrrq_pkg::CMD_DEQUEUE, 1'b0, 8'd0, 32'd0,
			1'b1, pfrrq_pkg::ST_EMPTY, 4'd0, 32'd0};
		dir_table[1]  = '{pfrrq_pkg::CMD_ENQUEUE, 1'b0, 8'd1, 32'd1,
			1'b1, pfrrq_pkg::ST_DROP_UNCL, 4'd0, 32'd0};
		dir_table[2]  = '{pfrrq_pkg::CMD_ENQUEUE, 1'b1, 8'd0, 32'hFFFF_FFFF,
			1'b1, pfrrq_pkg::ST_DROP_UNCL, 4'd0, 32'd0};
		dir_table[3]  = '{pfrrq_pkg::CMD_ENQUEUE, 1'b0, 8'd0, 32'hFFFF_FFFF,
			1'b1, pfrrq_pkg::ST_ENQ, 4'd0, 32'd0};
		dir_table[4]  = '{pfrrq_pkg::CMD_ENQUEUE, 1'b0, 8'd255, 32'h1234_5678,
			1'b1, pfrrq_pkg::ST_DROP_UNCL, 4'd0, 32'd0};
		dir_table[5]  = '{pfrrq_pkg::CMD_ENQUEUE, 1'b0, 8'd1, 32'd0,
			1'b1, pfrrq_pkg::ST_ENQ, 4'd1, 32'd0};
		dir_table[6]  = '{pfrrq_pkg::CMD_ENQUEUE, 1'b0, 8'd2, 32'h8000_0001,
			1'b1, pfrrq_pkg::ST_ENQ, 4'd2, 32'd0};
		dir_table[7]  = '{pfrrq_pkg::CMD_ENQUEUE, 1'b0, 8'd0, 32'd1,
			1'b0, pfrrq_pkg::ST_ENQ, 4'd0, 32'd0};
		dir_table[8]  = '{pfrrq_pkg::CMD_DEQUEUE, 1'b0, 8'd0, 32'd0,
			1'b1, pfrrq_pkg::ST_DEQ, 4'd0, 32'hFFFF_FFFF};
		dir_table[9]  = '{pfrrq_pkg::CMD_DEQUEUE, 1'b0, 8'd0, 32'd0,
			1'b1, pfrrq_pkg::ST_DEQ, 4'd1, 32'd0};
		dir_table[10] = '{pfrrq_pkg::CMD_DEQUEUE, 1'b0, 8'd0, 32'd0,
			1'b1, pfrrq_pkg::ST_DEQ, 4'd2, 32'h8000_0001};
		dir_table[11] = '{pfrrq_pkg::CMD_DEQUEUE, 1'b0, 8'd0, 32'd0,
			1'b0, pfrrq_pkg::ST_ENQ, 4'd0, 32'd0};
		dir_table[12] = '{pfrrq_pkg::CMD_DEQUEUE, 1'b0, 8'd0, 32'd0,
			1'b1, pfrrq_pkg::ST_EMPTY, 4'd0, 32'd0};
		dir_table[13] = '{pfrrq_pkg::CMD_ENQUEUE, 1'b1, 8'd200, 32'h5A5A_5A5A,
			1'b1, pfrrq_pkg::ST_DROP_UNCL, 4'd0, 32'd0};
		dir_table[14] = '{pfrrq_pkg::CMD_ENQUEUE, 1'b0, 8'd3, 32'hDEAD_BEEF,
			1'b0, pfrrq_pkg::ST_ENQ, 4'd0, 32'd0};
		dir_table[15] = '{pfrrq_pkg::CMD_DEQUEUE, 1'b1, 8'd255, 32'hFFFF_FFFF,
			1'b0, pfrrq_pkg::ST_ENQ, 4'd0, 32'd0};
		dir_table[16] = '{pfrrq_pkg::CMD_ENQUEUE, 1'b0, 8'd4, 32'hA5A5_A5A5,
			1'b0, pfrrq_pkg::ST_ENQ, 4'd0, 32'd0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(36, 62);
		for (int k = 0; k < DIR_ROWS; k++)
			push_word(dir_table[k]);
		push_random(200, 6);
		drain();

		set_queue_limit(7'd1);
		push_random(150, 9);
		drain();

		set_idling(62, 36);
		set_queue_limit(7'd3);
		hold_armed <= 1'b1;
		push_random(150, 12);
		drain();

		set_queue_limit(7'd0);
		push_random(40, 14);
		drain();

		set_idling(0, 0);
		set_queue_limit(7'd127);
		push_burst();
		push_random(50, 16);
		drain();

		set_queue_limit(7'd64);
		push_random(50, 16);
		drain();

		$display("Covered %0d request words and %0d checked responses",
			words_taken, rsp_checked);
		$display("over limits 64, 1, 3, 0, 127 and 64 again.");
		$display("Responses: %0d enqueued, %0d unclassified, %0d full, %0d dequeued, %0d empty.",
			status_seen[pfrrq_pkg::ST_ENQ], status_seen[pfrrq_pkg::ST_DROP_UNCL],
			status_seen[pfrrq_pkg::ST_DROP_FULL], status_seen[pfrrq_pkg::ST_DEQ],
			status_seen[pfrrq_pkg::ST_EMPTY]);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/pfrrq_pkg.sv
sv/pfrrq_if.sv
sv/per_flow_round_robin_queue_unit.sv
bench/tb.sv
